>>> hdl/loop_segment_timing_stats_core_defines.svh
// Assertion macros for the checker file lsts_chk.sv.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and held off while reset is asserted (active low).
`ifndef LOOP_SEGMENT_TIMING_STATS_CORE_DEFINES_SVH
`define LOOP_SEGMENT_TIMING_STATS_CORE_DEFINES_SVH

// Same-cycle implication.
`define LSTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsts assertion failed");

// Next-cycle implication.
`define LSTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsts assertion failed");

`endif

>>> hdl/lsts_pkg.sv
// ----------------------------------------------------------------------------
// lsts_pkg
// Widths, codes and the statistics entry type of the loop timing profiler.
// ----------------------------------------------------------------------------
package lsts_pkg;

  localparam int MAX_SEGS   = 8;
  localparam int ENTRIES    = MAX_SEGS + 1;           // period plus segments
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int SEGN_W     = $clog2(MAX_SEGS + 2);   // counts up to MAX_SEGS+1

  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int ID_W       = 4;
  localparam int ACT_W      = 4;
  localparam int WIN_W      = 16;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SEGS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPS_WIN   = 2'd1;

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd100;

  typedef struct packed {
    logic [TIME_W-1:0] mn;
    logic [TIME_W-1:0] mx;
    logic [TIME_W-1:0] sm;
  } stats_t;

  localparam stats_t STATS_EMPTY = '{mn: {TIME_W{1'b1}}, mx: '0, sm: '0};

endpackage

>>> hdl/lsts_ifs.sv
// ----------------------------------------------------------------------------
// lsts_ifs
// Valid/ready channels of the profiler: events in, records out, config writes.
// ----------------------------------------------------------------------------
interface lsts_in_if import lsts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, kind, time_us, input ready);
  modport sink   (input valid, kind, time_us, output ready);
endinterface

interface lsts_out_if import lsts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   record_id;
  logic [TIME_W-1:0] min_us;
  logic [TIME_W-1:0] avg_us;
  logic [TIME_W-1:0] max_us;
  logic              last;

  modport source (output valid, record_id, min_us, avg_us, max_us, last, input ready);
  modport sink   (input valid, record_id, min_us, avg_us, max_us, last, output ready);
endinterface

interface lsts_cfg_if import lsts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/loop_segment_timing_stats_core.sv
// Event handling: the event is taken, its stats entry is read from the
// stats memory, then merged and written back; the next event is taken once the block is idle again.
// Report, per record: read, capture, 32 steps of the one-bit-per-cycle
// divider for the average, output load; a report holds 1 + min(active_segments, 8) records.
// Reset (rst_n low, synchronous): control state and per-entry valid bits clear, so
// every entry reads as empty (min all ones, max and sum zero); no clearing pass.
// ----------------------------------------------------------------------------
// loop_segment_timing_stats_core
// Windowed min/average/max profiler for loop periods and loop segment times.
// ----------------------------------------------------------------------------
module loop_segment_timing_stats_core
  import lsts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lsts_in_if.sink    in_if,
  lsts_out_if.source out_if,
  lsts_cfg_if.sink   cfg_if
);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;  // wait for an event
  localparam logic [2:0] S_UPD     = 3'd1;  // merge the duration, write back
  localparam logic [2:0] S_RPT_RD  = 3'd2;  // read one record of the report
  localparam logic [2:0] S_RPT_CAP = 3'd3;  // capture it, start the divider
  localparam logic [2:0] S_DIV     = 3'd4;  // sum / window, one bit a cycle
  localparam logic [2:0] S_RPT_OUT = 3'd5;  // hand the record to the output

  logic [2:0] state_r, state_nxt;

  // Configuration
  logic [ACT_W-1:0] act_r;
  logic [WIN_W-1:0] win_r;

  // Loop tracking
  logic [TIME_W-1:0] prev_begin_r;
  logic              begin_seen_r;
  logic [TIME_W-1:0] seg_start_r;
  logic [SEGN_W-1:0] seg_num_r;
  logic [WIN_W-1:0]  loops_r;

  // Event in flight
  logic [TIME_W-1:0] dur_r;
  logic              rec_r;
  logic              rpt_pend_r;

  // Stats memory, one entry per record id; entry 0 is the loop period
  stats_t            mem [ENTRIES];
  stats_t            rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              mem_we;
  stats_t            upd;
  logic [ENTRIES-1:0] vld_r;
  stats_t            cur;

  // Report and divider
  logic [ADDR_W-1:0]    rpt_idx_r;
  logic [TIME_W-1:0]    mn_r, mx_r;
  logic [TIME_W-1:0]    quo_r;
  logic [WIN_W-1:0]     rem_r;
  logic [WIN_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WIN_W:0]       div_sh;
  logic                 div_ge;
  logic [WIN_W-1:0]     rem_nxt;

  // Output register
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_min_r, out_avg_r, out_max_r;
  logic              out_last_r;
  logic              out_load;

  // Derived controls
  logic [ADDR_W-1:0] eff_segs;
  logic [WIN_W-1:0]  eff_win;
  logic              in_take;
  logic              cfg_take;
  logic [TIME_W-1:0] in_dur;
  logic              in_rec;
  logic              seg_rec;
  logic [ADDR_W-1:0] in_addr;
  logic [WIN_W-1:0]  loops_inc;
  logic              in_rpt;
  logic              rpt_last;

  // Clamp the segment count to the table size and a zero window to one.
  assign eff_segs = (act_r > ACT_W'(MAX_SEGS)) ? ADDR_W'(MAX_SEGS) : ADDR_W'(act_r);
  assign eff_win  = (win_r == '0) ? WIN_W'(1) : win_r;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_take     = cfg_if.valid;

  // Classify the incoming event: which entry it touches and whether it records.
  assign seg_rec   = (seg_num_r < SEGN_W'(eff_segs));
  assign loops_inc = loops_r + WIN_W'(1);
  assign in_rpt    = (in_if.kind == KIND_END) &&
                     ((loops_inc == '0) || (loops_inc >= eff_win));

  always_comb begin
    in_dur  = in_if.time_us - seg_start_r;
    in_rec  = 1'b0;
    in_addr = '0;
    case (in_if.kind)
      KIND_BEGIN: begin
        in_dur = in_if.time_us - prev_begin_r;
        in_rec = begin_seen_r;
      end
      KIND_SEG, KIND_END: begin
        in_rec  = seg_rec;
        in_addr = seg_rec ? ADDR_W'(seg_num_r + SEGN_W'(1)) : '0;
      end
      default: begin
        in_rec = 1'b0;
      end
    endcase
  end

  // Memory address: the event's entry while idle, the report index otherwise.
  assign rd_addr = (state_r == S_IDLE) ? in_addr : rpt_idx_r;

  // An entry whose valid bit is clear holds its empty value.
  assign cur = vld_r[rd_addr_r] ? rd_data_r : STATS_EMPTY;

  always_comb begin
    upd.mn = (dur_r < cur.mn) ? dur_r : cur.mn;
    upd.mx = (dur_r > cur.mx) ? dur_r : cur.mx;
    upd.sm = cur.sm + dur_r;
  end

  assign mem_we = (state_r == S_UPD) && rec_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rd_addr_r] <= upd;
    end
    rd_data_r <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // Restoring divider step: shift one dividend bit into the remainder.
  assign div_sh  = {rem_r, quo_r[TIME_W-1]};
  assign div_ge  = (div_sh >= {1'b0, div_r});
  assign rem_nxt = div_ge ? WIN_W'(div_sh - {1'b0, div_r}) : div_sh[WIN_W-1:0];

  assign rpt_last = (rpt_idx_r == eff_segs);
  assign out_load = (state_r == S_RPT_OUT) && (!out_valid_r || out_if.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_take) state_nxt = S_UPD;
      S_UPD:     state_nxt = rpt_pend_r ? S_RPT_RD : S_IDLE;
      S_RPT_RD:  state_nxt = S_RPT_CAP;
      S_RPT_CAP: state_nxt = S_DIV;
      S_DIV:     if (cnt_r == DIV_CNT_W'(TIME_W - 1)) state_nxt = S_RPT_OUT;
      S_RPT_OUT: begin
        if (out_load) state_nxt = rpt_last ? S_IDLE : S_RPT_RD;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      act_r        <= ACT_RESET;
      win_r        <= WIN_RESET;
      prev_begin_r <= '0;
      begin_seen_r <= 1'b0;
      seg_start_r  <= '0;
      seg_num_r    <= '0;
      loops_r      <= '0;
      rpt_pend_r   <= 1'b0;
      rec_r        <= 1'b0;
      vld_r        <= '0;
      rpt_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_take) begin
        case (cfg_if.index)
          CFG_ACTIVE_SEGS: act_r <= cfg_if.data[ACT_W-1:0];
          CFG_LOOPS_WIN:   win_r <= cfg_if.data[WIN_W-1:0];
          default:         ;
        endcase
      end

      // Advance the loop tracking on each accepted begin, segment or end event.
      if (in_take) begin
        rec_r      <= in_rec;
        rpt_pend_r <= in_rpt;
        case (in_if.kind)
          KIND_BEGIN: begin
            prev_begin_r <= in_if.time_us;
            begin_seen_r <= 1'b1;
            seg_num_r    <= '0;
            seg_start_r  <= in_if.time_us;
          end
          KIND_SEG, KIND_END: begin
            if (seg_num_r != SEGN_W'(MAX_SEGS + 1)) begin
              seg_num_r <= seg_num_r + SEGN_W'(1);
            end
            seg_start_r <= in_if.time_us;
            if (in_if.kind == KIND_END) begin
              loops_r <= in_rpt ? '0 : loops_inc;
            end
          end
          default: ;
        endcase
      end

      if (mem_we) begin
        vld_r[rd_addr_r] <= 1'b1;
      end

      if (state_r == S_UPD) begin
        rpt_idx_r <= '0;
      end

      // Drop the entry back to empty once it has been read for the report.
      if (state_r == S_RPT_CAP) begin
        vld_r[rd_addr_r] <= 1'b0;
      end

      if (out_load && !rpt_last) begin
        rpt_idx_r <= rpt_idx_r + ADDR_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Duration capture and report datapath: capture, divide, load the output register
  always_ff @(posedge clk) begin
    if (in_take) begin
      dur_r <= in_dur;
    end
    if (state_r == S_RPT_CAP) begin
      mn_r  <= cur.mn;
      mx_r  <= cur.mx;
      quo_r <= cur.sm;
      rem_r <= '0;
      div_r <= eff_win;
      cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      quo_r <= {quo_r[TIME_W-2:0], div_ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (out_load) begin
      out_id_r   <= ID_W'(rpt_idx_r);
      out_min_r  <= mn_r;
      out_avg_r  <= quo_r;
      out_max_r  <= mx_r;
      out_last_r <= rpt_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.record_id = out_id_r;
  assign out_if.min_us    = out_min_r;
  assign out_if.avg_us    = out_avg_r;
  assign out_if.max_us    = out_max_r;
  assign out_if.last      = out_last_r;

endmodule

>>> hdl/lsts_chk.sv
// ----------------------------------------------------------------------------
// lsts_chk
// Port-level checks of the profiler, bound to the profiler core.
// ----------------------------------------------------------------------------
`include "loop_segment_timing_stats_core_defines.svh"

module lsts_chk
  import lsts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [TIME_W-1:0] out_min,
  input logic [TIME_W-1:0] out_max
);

  // A stalled record stays offered.
  `LSTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // An accepted event keeps the block busy for the following cycle.
  `LSTS_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

  // No event is taken while a report is still partway out.
  `LSTS_ASSERT_IMP(a_report_blocks_in, clk, rst_n, out_valid && !out_last, !in_ready)

  // Min above max only for an entry that recorded nothing.
  `LSTS_ASSERT_IMP(a_min_max_order, clk, rst_n, out_valid && (out_min > out_max),
                   (out_min == {TIME_W{1'b1}}) && (out_max == '0))

endmodule

bind loop_segment_timing_stats_core lsts_chk u_lsts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.last),
  .out_min   (out_if.min_us),
  .out_max   (out_if.max_us)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the loop timing profiler: drives timestamped loop
// events and register writes, predicts every report record and checks each
// record on the output channel in order.
// ----------------------------------------------------------------------------
module testbench;
  import lsts_pkg::*;

  // Kind code the block has to ignore, and register indexes with no register.
  localparam logic [KIND_W-1:0]    KIND_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

  // Leave a margin after the queues empty, also for items with no record.
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] time_us;
  } loop_event_t;

  typedef struct packed {
    logic [ID_W-1:0]   record_id;
    logic [TIME_W-1:0] min_us;
    logic [TIME_W-1:0] avg_us;
    logic [TIME_W-1:0] max_us;
    logic              last;
  } stats_record_t;

  // --------------------------------------------------------------------------
  // Clock, reset and channel drive
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic                  ev_valid  = 1'b0;
  logic [KIND_W-1:0]     ev_kind   = '0;
  logic [TIME_W-1:0]     ev_time   = '0;
  logic                  rec_ready = 1'b0;
  logic                  reg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  reg_index = '0;
  logic [CFG_DATA_W-1:0] reg_data  = '0;

  lsts_in_if  ev_if ();
  lsts_out_if rec_if ();
  lsts_cfg_if reg_if ();

  assign ev_if.valid   = ev_valid;
  assign ev_if.kind    = ev_kind;
  assign ev_if.time_us = ev_time;
  assign rec_if.ready  = rec_ready;
  assign reg_if.valid  = reg_valid;
  assign reg_if.index  = reg_index;
  assign reg_if.data   = reg_data;

  loop_segment_timing_stats_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (ev_if),
    .out_if (rec_if),
    .cfg_if (reg_if)
  );

  // Idling knobs, changed by the stimulus only between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  loop_event_t   pending_events[$];
  stats_record_t expected_records[$];
  int            fail_count   = 0;
  int            records_seen = 0;

  // --------------------------------------------------------------------------
  // Profiler prediction: own copy of the statistics and loop tracking.
  // Entry 0 holds the loop period, entry k+1 holds segment k.
  // --------------------------------------------------------------------------
  stats_t            stat_entry [ENTRIES];
  logic [TIME_W-1:0] last_begin_us;
  logic              begin_seen;
  logic [TIME_W-1:0] seg_open_us;
  logic [SEGN_W-1:0] seg_index;
  logic [WIN_W-1:0]  loops_done;
  logic [ACT_W-1:0]  act_segs;
  logic [WIN_W-1:0]  win_len;

  function automatic int unsigned tracked_segments();
    return (act_segs > MAX_SEGS) ? MAX_SEGS : act_segs;
  endfunction

  function automatic logic [WIN_W-1:0] window_len();
    return (win_len == '0) ? WIN_W'(1) : win_len;
  endfunction

  task automatic clear_profile();
    for (int i = 0; i < ENTRIES; i++) stat_entry[i] = STATS_EMPTY;
    last_begin_us = '0;
    begin_seen    = 1'b0;
    seg_open_us   = '0;
    seg_index     = '0;
    loops_done    = '0;
    act_segs      = ACT_RESET;
    win_len       = WIN_RESET;
  endtask

  task automatic record_duration(int idx, logic [TIME_W-1:0] dur);
    if (dur < stat_entry[idx].mn) stat_entry[idx].mn = dur;
    if (dur > stat_entry[idx].mx) stat_entry[idx].mx = dur;
    stat_entry[idx].sm = stat_entry[idx].sm + dur;
  endtask

  task automatic close_segment(logic [TIME_W-1:0] t);
    // Boundaries past the tracked count only advance the counter.
    if (seg_index < tracked_segments())
      record_duration(int'(seg_index) + 1, t - seg_open_us);
    if (seg_index < MAX_SEGS + 1) seg_index = seg_index + 1'b1;
    seg_open_us = t;
  endtask

  task automatic emit_report();
    int unsigned   n;
    stats_record_t rec;
    n = tracked_segments();
    for (int unsigned i = 0; i <= n; i++) begin
      rec.record_id = ID_W'(i);
      rec.min_us    = stat_entry[i].mn;
      rec.avg_us    = stat_entry[i].sm / window_len();
      rec.max_us    = stat_entry[i].mx;
      rec.last      = (i == n);
      expected_records.push_back(rec);
    end
    // Segments outside the tracked count keep their statistics.
    for (int unsigned i = 0; i <= n; i++) stat_entry[i] = STATS_EMPTY;
    loops_done = '0;
  endtask

  task automatic apply_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t);
    case (kind)
      KIND_BEGIN: begin
        // The first begin after reset has no previous begin to measure from.
        if (begin_seen) record_duration(0, t - last_begin_us);
        last_begin_us = t;
        begin_seen    = 1'b1;
        seg_index     = '0;
        seg_open_us   = t;
      end
      KIND_SEG: begin
        close_segment(t);
      end
      KIND_END: begin
        close_segment(t);
        loops_done = loops_done + 1'b1;
        if (loops_done == '0 || loops_done >= window_len()) emit_report();
      end
      default: begin
      end
    endcase
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ACTIVE_SEGS: act_segs = data[ACT_W-1:0];
      CFG_LOOPS_WIN:   win_len  = data[WIN_W-1:0];
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Record checking
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_record();
    stats_record_t exp_rec;
    records_seen++;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record: expected none, actual id %0d min %h avg %h max %h last %b",
               $time, rec_if.record_id, rec_if.min_us, rec_if.avg_us, rec_if.max_us,
               rec_if.last);
      fail_count++;
    end else begin
      exp_rec = expected_records.pop_front();
      compare_field("record_id", TIME_W'(exp_rec.record_id), TIME_W'(rec_if.record_id));
      compare_field("min_us",    exp_rec.min_us,    rec_if.min_us);
      compare_field("avg_us",    exp_rec.avg_us,    rec_if.avg_us);
      compare_field("max_us",    exp_rec.max_us,    rec_if.max_us);
      compare_field("last",      TIME_W'(exp_rec.last), TIME_W'(rec_if.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: advance the event channel from the pending queue, with random gaps.
  // Hold the current transaction until the block takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      ev_valid <= 1'b0;
    end else if (!ev_valid || ev_if.ready) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ev_valid <= 1'b1;
        ev_kind  <= pending_events[0].kind;
        ev_time  <= pending_events[0].time_us;
        void'(pending_events.pop_front());
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    rec_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check records first, then predict from the event and register
  // transactions taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rec_if.valid && rec_ready) check_record();
      if (ev_valid && ev_if.ready) apply_event(ev_kind, ev_time);
      if (reg_valid && reg_if.ready) apply_register(reg_index, reg_data);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] clock_us = '0;

  task automatic push_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t);
    loop_event_t ev;
    ev.kind    = kind;
    ev.time_us = t;
    pending_events.push_back(ev);
  endtask

  // Step the free-running timestamp: mostly short gaps, some long, some wraps.
  function automatic logic [TIME_W-1:0] advance_clock();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6)       clock_us = clock_us + $urandom_range(0, 200);
    else if (pick < 8)  clock_us = clock_us + $urandom_range(0, 1 << 20);
    else if (pick == 8) clock_us = clock_us + $urandom;
    return clock_us;
  endfunction

  task automatic push_loop(int boundaries);
    push_event(KIND_BEGIN, advance_clock());
    repeat (boundaries) push_event(KIND_SEG, advance_clock());
    push_event(KIND_END, advance_clock());
  endtask

  // Wait until the block has drained every transaction and record.
  // Sample between edges so the driver's and monitor's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || ev_valid || expected_records.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= data;
    do @(posedge clk);
    while (!reg_if.ready);
    reg_valid <= 1'b0;
  endtask

  // Mostly well-formed loops with random content; the rest is noise and
  // loops missing their begin or their end.
  task automatic run_traffic(int n_items);
    int          count;
    int unsigned pick;
    int          segs;
    logic [KIND_W-1:0] kind;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        segs = ($urandom_range(3) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
        push_loop(segs);
        count += segs + 2;
      end else if (pick < 90) begin
        kind = KIND_W'($urandom_range(0, 3));
        push_event(kind, $urandom);
        if (kind != KIND_UNUSED) count++;
      end else begin
        segs = $urandom_range(1, 4);
        if ($urandom_range(1) == 1) push_event(KIND_BEGIN, advance_clock());
        repeat (segs) push_event($urandom_range(1) ? KIND_SEG : KIND_END, advance_clock());
        count += segs;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_profile();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: events before any begin, ignored kind, first begin, wrapped
    // and zero durations, all at the reset register values.
    push_event(KIND_SEG,    32'd10);
    push_event(KIND_END,    32'hFFFF_FFF0);
    push_event(KIND_UNUSED, $urandom);
    push_event(KIND_BEGIN,  32'hFFFF_FFFF);
    push_event(KIND_SEG,    32'h0000_0003);
    push_event(KIND_SEG,    32'h0000_0003);
    push_event(KIND_END,    32'hFFFF_FFFE);

    // Window of zero acts as one and reports at once; extra boundaries saturate.
    write_reg(CFG_LOOPS_WIN, 16'd0);
    clock_us = 32'h7FFF_FFFF;
    push_event(KIND_BEGIN, clock_us);
    repeat (9) push_event(KIND_SEG, advance_clock());
    push_event(KIND_END, advance_clock());

    // No tracked segments: the period record alone closes the report.
    write_reg(CFG_ACTIVE_SEGS, 16'd0);
    push_loop(2);

    // Segment count above the maximum, two loops per window.
    write_reg(CFG_ACTIVE_SEGS, 16'd15);
    write_reg(CFG_LOOPS_WIN, 16'd2);
    push_loop(3);
    push_loop(1);

    // Three tracked segments; upper segments keep their statistics.
    write_reg(CFG_ACTIVE_SEGS, 16'd3);
    write_reg(CFG_LOOPS_WIN, 16'd1);
    write_reg(CFG_IDX_SPARE0, CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_SPARE1, CFG_DATA_W'($urandom));
    push_loop(5);

    // Random phase: no idling.
    write_reg(CFG_ACTIVE_SEGS, {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))});
    write_reg(CFG_LOOPS_WIN, CFG_DATA_W'($urandom_range(1, 4)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(50);

    // Random phase: sender mostly idle; widest window, then shorten it.
    write_reg(CFG_ACTIVE_SEGS, 16'd8);
    write_reg(CFG_LOOPS_WIN, 16'hFFFF);
    send_idle_pct = 79;
    run_traffic(25);
    write_reg(CFG_LOOPS_WIN, CFG_DATA_W'($urandom_range(1, 3)));
    run_traffic(25);

    // Random phase: receiver mostly stalling.
    write_reg(CFG_ACTIVE_SEGS, CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(CFG_LOOPS_WIN, CFG_DATA_W'($urandom_range(0, 4)));
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_traffic(50);

    // Random phase: both sides idle; keep going until enough records came.
    write_reg(CFG_ACTIVE_SEGS, CFG_DATA_W'($urandom_range(1, 8)));
    write_reg(CFG_LOOPS_WIN, CFG_DATA_W'($urandom_range(1, 4)));
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_traffic(25);
    wait_idle();
    run_traffic(25);
    while (records_seen < 60) begin
      run_traffic(20);
      wait_idle();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lsts_pkg.sv
hdl/lsts_ifs.sv
hdl/loop_segment_timing_stats_core.sv
hdl/lsts_chk.sv
test/testbench.sv
